// File: hdl/hed_pkg.sv
// shared types, constants and the entity name table for the entity decoder
// no dependencies; used by hed_name_match and html_entity_decoder_core
package hed_pkg;

    localparam int NAME_COUNT = 102;
    localparam int NAME_BYTES = 6;
    localparam int DEPTH_W    = 3;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DIGITS = 2'd1,
        MODE_NAME   = 2'd2,
        MODE_TAIL   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_CONSUMED = 2'd1,
        ST_DONE_USE = 2'd2,
        ST_DONE_NOT = 2'd3
    } status_t;

    typedef logic [NAME_COUNT-1:0] mask_t;

    typedef struct packed {
        logic       hit;   // some name continues with this byte
        logic       done;  // a full name ends on this byte
        logic [7:0] val;   // code of that name
        mask_t      mask;  // names still alive after this byte
    } match_t;

    // names right-justified, first character in the highest used byte
    localparam logic [8*NAME_BYTES-1:0] NAME_TXT [NAME_COUNT] = '{
        "lt", "gt", "amp", "quot", "nbsp", "Nbsp",
        "trade", "iexcl", "cent", "pound", "curren",
        "yen", "brvbar", "sect", "uml", "copy",
        "ordf", "laquo", "not", "shy", "reg",
        "hibar", "deg", "plusmn", "sup2", "sup3",
        "acute", "micro", "para", "middot", "cedil",
        "sup1", "ordm", "raquo", "frac14", "frac12",
        "frac34", "iquest", "Agrave", "Aacute", "Acirc",
        "Atilde", "Auml", "Aring", "AElig", "Ccedil",
        "Egrave", "Eacute", "Ecirc", "Euml", "Igrave",
        "Iacute", "Icirc", "Iuml", "ETH", "Ntilde",
        "Ograve", "Oacute", "Ocirc", "Otilde", "Ouml",
        "times", "Oslash", "Ugrave", "Uacute", "Ucirc",
        "Uuml", "Yacute", "THORN", "szlig", "agrave",
        "aacute", "acirc", "atilde", "auml", "aring",
        "aelig", "ccedil", "egrave", "eacute", "ecirc",
        "euml", "igrave", "iacute", "icirc", "iuml",
        "eth", "ntilde", "ograve", "oacute", "ocirc",
        "otilde", "ouml", "divide", "oslash", "ugrave",
        "uacute", "ucirc", "uuml", "yacute", "thorn",
        "yuml"
    };

    localparam logic [7:0] NAME_VAL [NAME_COUNT] = '{
        8'd60, 8'd62, 8'd38, 8'd34, 8'd32, 8'd32,
        8'd153, 8'd161, 8'd162, 8'd163, 8'd164,
        8'd165, 8'd166, 8'd167, 8'd168, 8'd169,
        8'd170, 8'd171, 8'd172, 8'd173, 8'd174,
        8'd175, 8'd176, 8'd177, 8'd178, 8'd179,
        8'd180, 8'd181, 8'd182, 8'd183, 8'd184,
        8'd185, 8'd186, 8'd187, 8'd188, 8'd189,
        8'd190, 8'd191, 8'd192, 8'd193, 8'd194,
        8'd195, 8'd196, 8'd197, 8'd198, 8'd199,
        8'd200, 8'd201, 8'd202, 8'd203, 8'd204,
        8'd205, 8'd206, 8'd207, 8'd208, 8'd209,
        8'd210, 8'd211, 8'd212, 8'd213, 8'd214,
        8'd215, 8'd216, 8'd217, 8'd218, 8'd219,
        8'd220, 8'd221, 8'd222, 8'd223, 8'd224,
        8'd225, 8'd226, 8'd227, 8'd228, 8'd229,
        8'd230, 8'd231, 8'd232, 8'd233, 8'd234,
        8'd235, 8'd236, 8'd237, 8'd238, 8'd239,
        8'd240, 8'd241, 8'd242, 8'd243, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249,
        8'd250, 8'd251, 8'd252, 8'd253, 8'd254,
        8'd255
    };

    // number of non-zero bytes of a table name
    function automatic logic [DEPTH_W-1:0] name_len(input logic [8*NAME_BYTES-1:0] txt);
        logic [DEPTH_W-1:0] n;
        n = '0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (txt[8*b +: 8] != 8'h00) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/hed_name_match.sv
// one lane per table name: compares the byte at the current depth
// depends on hed_pkg for the name table and match_t
module hed_name_match (
    input  hed_pkg::mask_t                mask_in,
    input  logic [hed_pkg::DEPTH_W-1:0]   depth,
    input  logic [7:0]                    ch,
    output hed_pkg::match_t               result
);

    always_comb begin
        logic [hed_pkg::DEPTH_W-1:0] len;
        logic [hed_pkg::DEPTH_W-1:0] pos;
        logic [7:0]                  nb;
        logic                        alive;
        result = '0;
        for (int j = 0; j < hed_pkg::NAME_COUNT; j++) begin
            len   = hed_pkg::name_len(hed_pkg::NAME_TXT[j]);
            pos   = len - 1'b1 - depth;
            nb    = 8'(hed_pkg::NAME_TXT[j] >> {pos, 3'b000});
            alive = mask_in[j] && (len > depth) && (nb == ch);
            result.mask[j] = alive;
            if (alive) begin
                result.hit = 1'b1;
                if (len == depth + 1'b1) begin
                    result.done = 1'b1;
                    result.val  = result.val | hed_pkg::NAME_VAL[j];
                end
            end
        end
    end

endmodule

// File: hdl/html_entity_decoder_core.sv
// top level of the character entity decoder: state, digit accumulator, output register
// depends on hed_pkg and hed_name_match
//
// Takes the bytes that follow an ampersand, one byte per transfer, and gives
// exactly one result per byte: status (ignored, consumed, done with the byte
// consumed, done without it) and the decoded code. A byte is taken every
// cycle unless the output stalls; a result appears in the cycle after its byte
// and sits in an output register, and a new byte is still taken while that
// result waits, as long as it is taken out in the same cycle. Named entities
// are matched by a row of per-name lanes that hold a live-candidate mask, so
// each byte is one trie step; decimal references accumulate modulo 65536. A
// ';' right after a complete entity is consumed with it. start_req restarts
// decoding at any time and silently drops an entity in progress.
module html_entity_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] code
);

    hed_pkg::mode_t               mode_reg, mode_next;
    logic [15:0]                  accum_reg, accum_next;
    hed_pkg::mask_t               mask_reg, mask_next;
    logic [hed_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic                         out_valid_reg;
    hed_pkg::status_t             status_reg, status_next;
    logic [15:0]                  code_reg, code_next;

    hed_pkg::mask_t               mask_in;
    logic [hed_pkg::DEPTH_W-1:0]  depth_in;
    hed_pkg::match_t              match;
    hed_pkg::mode_t               mode_eff;
    hed_pkg::status_t             end_status;
    logic                         accept;
    logic                         is_digit;

    // output register frees up when its result is taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign code      = code_reg;

    // a start byte walks from the root with every name still a candidate
    assign mask_in  = start_req ? '1 : mask_reg;
    assign depth_in = start_req ? '0 : depth_reg;
    assign mode_eff = start_req ? hed_pkg::MODE_NAME : mode_reg;

    hed_name_match u_match (
        .mask_in (mask_in),
        .depth   (depth_in),
        .ch      (ch),
        .result  (match)
    );

    assign is_digit   = (ch >= hed_pkg::CH_ZERO) && (ch <= hed_pkg::CH_NINE);
    assign end_status = (ch == hed_pkg::CH_SEMI) ? hed_pkg::ST_DONE_USE
                                                 : hed_pkg::ST_DONE_NOT;

    always_comb begin
        mode_next   = mode_reg;
        accum_next  = accum_reg;
        mask_next   = mask_reg;
        depth_next  = depth_reg;
        status_next = hed_pkg::ST_IGNORED;
        code_next   = '0;
        if (start_req && (ch == hed_pkg::CH_HASH)) begin
            // numeric reference begins
            mode_next   = hed_pkg::MODE_DIGITS;
            accum_next  = '0;
            status_next = hed_pkg::ST_CONSUMED;
        end else begin
            unique case (mode_eff)
                hed_pkg::MODE_DIGITS: begin
                    if (is_digit) begin
                        // accum * 10 + digit, wraps at 16 bits
                        accum_next  = (accum_reg << 3) + (accum_reg << 1)
                                    + {12'd0, 4'(ch - hed_pkg::CH_ZERO)};
                        status_next = hed_pkg::ST_CONSUMED;
                    end else begin
                        code_next   = accum_reg;
                        status_next = end_status;
                        mode_next   = hed_pkg::MODE_IDLE;
                    end
                end
                hed_pkg::MODE_NAME: begin
                    if (match.hit) begin
                        status_next = hed_pkg::ST_CONSUMED;
                        if (match.done) begin
                            accum_next = {8'd0, match.val};
                            mode_next  = hed_pkg::MODE_TAIL;
                        end else begin
                            mode_next  = hed_pkg::MODE_NAME;
                            mask_next  = match.mask;
                            depth_next = depth_in + 1'b1;
                        end
                    end else begin
                        // no edge: unknown name, code 0
                        status_next = end_status;
                        mode_next   = hed_pkg::MODE_IDLE;
                    end
                end
                hed_pkg::MODE_TAIL: begin
                    code_next   = accum_reg;
                    status_next = end_status;
                    mode_next   = hed_pkg::MODE_IDLE;
                end
                hed_pkg::MODE_IDLE: begin
                    status_next = hed_pkg::ST_IGNORED;
                end
                default: begin
                    status_next = hed_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    // decode state and output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg      <= hed_pkg::MODE_IDLE;
            accum_reg     <= '0;
            mask_reg      <= '1;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= hed_pkg::ST_IGNORED;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                accum_reg  <= accum_next;
                mask_reg   <= mask_next;
                depth_reg  <= depth_next;
                status_reg <= status_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            code_reg <= code_next;
        end
    end

    // a matched name always carries a nonzero code
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == hed_pkg::MODE_TAIL) |-> (accum_reg != 16'd0))
        else $error("tail mode holds zero code");

    // a name walk always keeps at least one candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == hed_pkg::MODE_NAME) |-> (mask_reg != '0))
        else $error("name walk lost all candidates");

    // depth never passes the longest name
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == hed_pkg::MODE_NAME) |-> (depth_reg < 3'(hed_pkg::NAME_BYTES)))
        else $error("name depth out of range");

    // code is only given with a finished entity
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == hed_pkg::ST_IGNORED
                       || status_reg == hed_pkg::ST_CONSUMED)) |-> (code == 16'd0))
        else $error("code nonzero on unfinished result");

    // an accepted byte always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted byte lost its result");

endmodule
